@@ hw/rtl/single_source_shortest_path_defines.svh @@
// assertion macros for the shortest path engine checker
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SSSP_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SSSP_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hw/rtl/sssp_pkg.sv @@
// shared types and constants of the shortest path engine
package sssp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VTX_W  = 4;
  localparam int WGT_W  = 16;
  localparam int DIST_W = 24;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 5;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] VCOUNT_RST = CNT_W'(16);
  localparam logic [VTX_W-1:0] SOURCE_RST = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT  = 1'b0,
    REG_SOURCE_VERTEX = 1'b1
  } reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [VTX_W-1:0]  edge_source;
    logic [VTX_W-1:0]  edge_target;
    logic [WGT_W-1:0]  edge_weight;
  } in_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last;
  } out_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load_edge;
    logic clear_edges;
    logic solve_init;
    logic scan_rd;
    logic visit;
    logic edge_rd;
    logic edge_chk;
    logic relax;
    logic out_rd;
    logic out_ld;
  } ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic scan_last;
    logic pick_vld;
    logic edge_avail;
    logic edge_match;
    logic out_free;
    logic out_last;
  } stat_t;

endpackage

@@ hw/rtl/sssp_ctrl.sv @@
// sequencer for edge loading and clearing, vertex selection, relaxation and result output
module sssp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sssp_pkg::CMD_W-1:0]  in_cmd_i,
  output logic                        in_ready_o,
  input  sssp_pkg::stat_t             stat_i,
  output sssp_pkg::ctrl_t             ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_PICK,
    S_EDGE,
    S_CHK,
    S_RELAX,
    S_OUT_RD,
    S_OUT_LD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_cmd_i)
            sssp_pkg::CMD_LOAD:  ctrl_o.load_edge = 1'b1;
            sssp_pkg::CMD_CLEAR: ctrl_o.clear_edges = 1'b1;
            sssp_pkg::CMD_SOLVE: begin
              ctrl_o.solve_init = 1'b1;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (stat_i.scan_last) state_d = S_SCAN_END;
      end
      // last compare of the scan lands here
      S_SCAN_END: state_d = S_PICK;
      S_PICK: begin
        if (stat_i.pick_vld) begin
          ctrl_o.visit = 1'b1;
          state_d = S_EDGE;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      S_EDGE: begin
        if (stat_i.edge_avail) begin
          ctrl_o.edge_rd = 1'b1;
          state_d = S_CHK;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_CHK: begin
        ctrl_o.edge_chk = 1'b1;
        state_d = stat_i.edge_match ? S_RELAX : S_EDGE;
      end
      S_RELAX: begin
        ctrl_o.relax = 1'b1;
        state_d = S_EDGE;
      end
      S_OUT_RD: begin
        ctrl_o.out_rd = 1'b1;
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (stat_i.out_free) begin
          ctrl_o.out_ld = 1'b1;
          state_d = stat_i.out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/sssp_datapath.sv @@
// edge table, distance memory, vertex scan, relaxation and output register
module sssp_datapath #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sssp_pkg::CFG_W-1:0]      cfg_data_i,
  input  sssp_pkg::in_t                   in_data_i,
  input  sssp_pkg::ctrl_t                 ctrl_i,
  output sssp_pkg::stat_t                 stat_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output sssp_pkg::out_t                  out_data_o
);

  localparam int VTX_W  = sssp_pkg::VTX_W;
  localparam int DW     = sssp_pkg::DIST_W;
  localparam int CNT_W  = sssp_pkg::CNT_W;
  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int IW     = (VW > VTX_W) ? VW : VTX_W;
  localparam int CW     = (NW > CNT_W) ? NW : CNT_W;
  localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW     = $clog2(MAX_EDGES + 1);
  localparam int SW     = (WEIGHT_BITS < sssp_pkg::WGT_W) ? WEIGHT_BITS : sssp_pkg::WGT_W;
  localparam int ENT_W  = 2 * VTX_W + SW;

  // configuration
  logic [CNT_W-1:0] vcount_q;
  logic [VTX_W-1:0] src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= sssp_pkg::VCOUNT_RST;
      src_q    <= sssp_pkg::SOURCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sssp_pkg::REG_VERTEX_COUNT:  vcount_q <= cfg_data_i[CNT_W-1:0];
        sssp_pkg::REG_SOURCE_VERTEX: src_q <= cfg_data_i[VTX_W-1:0];
        default: ;
      endcase
    end
  end

  // active vertex count, clamped to 1..MAX_VERTICES
  logic [CW-1:0] vc_ext;
  logic [CW-1:0] n_clamp;
  logic [NW-1:0] n_d, n_q;
  logic          src_ok;
  logic [IW-1:0] src_ext;
  logic [VW-1:0] src_idx;

  always_comb begin
    vc_ext = CW'(vcount_q);
    if (vc_ext == '0) begin
      n_clamp = CW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_clamp = CW'(MAX_VERTICES);
    end else begin
      n_clamp = vc_ext;
    end
    n_d     = n_clamp[NW-1:0];
    src_ok  = CW'(src_q) < n_clamp;
    src_ext = IW'(src_q);
    src_idx = src_ext[VW-1:0];
  end

  // edge table
  logic [ENT_W-1:0] edge_mem [MAX_EDGES];
  logic [ENT_W-1:0] edge_rd_q;
  logic [EW-1:0]    edge_total_q;
  logic [EW-1:0]    edge_idx_q;
  logic             edge_full;
  logic             edge_we;

  assign edge_full = (edge_total_q == EW'(MAX_EDGES));
  assign edge_we   = ctrl_i.load_edge && !edge_full;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_total_q[AW-1:0]] <= {in_data_i.edge_source, in_data_i.edge_target,
                                         in_data_i.edge_weight[SW-1:0]};
    end
    if (ctrl_i.edge_rd) begin
      edge_rd_q <= edge_mem[edge_idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      edge_idx_q   <= '0;
    end else begin
      if (ctrl_i.clear_edges) begin
        edge_total_q <= '0;
      end else if (edge_we) begin
        edge_total_q <= edge_total_q + EW'(1);
      end
      if (ctrl_i.visit) begin
        edge_idx_q <= '0;
      end else if (ctrl_i.edge_rd) begin
        edge_idx_q <= edge_idx_q + EW'(1);
      end
    end
  end

  logic [VTX_W-1:0] e_tail, e_head;
  logic [SW-1:0]    e_wgt;
  logic [IW-1:0]    head_ext;
  logic [VW-1:0]    head_idx;
  logic             e_match;

  assign e_tail   = edge_rd_q[ENT_W-1 -: VTX_W];
  assign e_head   = edge_rd_q[SW+VTX_W-1 -: VTX_W];
  assign e_wgt    = edge_rd_q[SW-1:0];
  assign head_ext = IW'(e_head);
  assign head_idx = head_ext[VW-1:0];

  // per-vertex flags
  logic [MAX_VERTICES-1:0] visited_q, reached_q;

  // current vertex and its distance
  logic [VW-1:0] u_q;
  logic [DW-1:0] du_q;
  assign e_match = (IW'(e_tail) == IW'(u_q)) && (CW'(e_head) < CW'(n_q));

  // saturating candidate distance
  logic [DW:0]   sum;
  logic [DW-1:0] cand;
  logic [DW-1:0] cand_q;
  logic [VW-1:0] h_q;
  assign sum  = (DW+1)'(du_q) + (DW+1)'(e_wgt);
  assign cand = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];

  // distance memory, unwritten entries are masked by reached_q
  logic [DW-1:0] dist_mem [MAX_VERTICES];
  logic [DW-1:0] dist_rd_q;
  logic [VW-1:0] scan_idx_q, out_idx_q;
  logic          upd;
  logic          dist_we;
  logic [VW-1:0] dist_wa;
  logic [DW-1:0] dist_wd;
  logic          dist_re;
  logic [VW-1:0] dist_ra;

  assign upd = !reached_q[h_q] || (cand_q < dist_rd_q);

  always_comb begin
    dist_we = 1'b0;
    dist_wa = h_q;
    dist_wd = cand_q;
    if (ctrl_i.solve_init && src_ok) begin
      dist_we = 1'b1;
      dist_wa = src_idx;
      dist_wd = '0;
    end else if (ctrl_i.relax && upd) begin
      dist_we = 1'b1;
    end
    dist_re = ctrl_i.scan_rd || ctrl_i.edge_chk || ctrl_i.out_rd;
    priority if (ctrl_i.scan_rd) begin
      dist_ra = scan_idx_q;
    end else if (ctrl_i.edge_chk) begin
      dist_ra = head_idx;
    end else begin
      dist_ra = out_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (dist_re) dist_rd_q <= dist_mem[dist_ra];
  end

  // minimum scan
  logic          scan_pend_q;
  logic [VW-1:0] scan_cur_q;
  logic [VW-1:0] pick_q;
  logic          pick_vld_q;
  logic [DW-1:0] low_q;
  logic          take;

  assign take = scan_pend_q && !visited_q[scan_cur_q] && reached_q[scan_cur_q]
                && (!pick_vld_q || (dist_rd_q < low_q));

  // output register
  logic         out_valid_q;
  sssp_pkg::out_t out_q;
  logic         out_free;
  logic         out_last;
  logic [IW-1:0] out_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_last = (NW'(out_idx_q) + NW'(1)) == n_q;
  assign out_ext  = IW'(out_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q   <= '0;
      reached_q   <= '0;
      n_q         <= NW'(1);
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      pick_vld_q  <= 1'b0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      scan_pend_q <= ctrl_i.scan_rd;
      if (ctrl_i.solve_init) begin
        visited_q  <= '0;
        reached_q  <= '0;
        if (src_ok) reached_q[src_idx] <= 1'b1;
        n_q        <= n_d;
        scan_idx_q <= '0;
        pick_vld_q <= 1'b0;
        out_idx_q  <= '0;
      end else begin
        if (ctrl_i.scan_rd) scan_idx_q <= scan_idx_q + VW'(1);
        if (take) pick_vld_q <= 1'b1;
        if (ctrl_i.visit) begin
          visited_q[pick_q] <= 1'b1;
          scan_idx_q <= '0;
          pick_vld_q <= 1'b0;
        end
        if (ctrl_i.relax && upd) reached_q[h_q] <= 1'b1;
        if (ctrl_i.out_ld) out_idx_q <= out_idx_q + VW'(1);
      end
      if (ctrl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_rd) scan_cur_q <= scan_idx_q;
    if (take) begin
      pick_q <= scan_cur_q;
      low_q  <= dist_rd_q;
    end
    if (ctrl_i.visit) begin
      u_q  <= pick_q;
      du_q <= low_q;
    end
    if (ctrl_i.edge_chk) begin
      cand_q <= cand;
      h_q    <= head_idx;
    end
    if (ctrl_i.out_ld) begin
      out_q.vertex    <= out_ext[VTX_W-1:0];
      out_q.distance  <= reached_q[out_idx_q] ? dist_rd_q : '0;
      out_q.reachable <= reached_q[out_idx_q];
      out_q.last      <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o.scan_last  = (NW'(scan_idx_q) + NW'(1)) == n_q;
    stat_o.pick_vld   = pick_vld_q;
    stat_o.edge_avail = edge_idx_q < edge_total_q;
    stat_o.edge_match = e_match;
    stat_o.out_free   = out_free;
    stat_o.out_last   = out_last;
  end

endmodule

@@ hw/rtl/single_source_shortest_path.sv @@
// top level of the single-source shortest path engine
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    in_data_i  (sssp_pkg::in_t)
//   out_*        output     out_valid/out_ready  out_data_o (sssp_pkg::out_t)
//   cfg_*        input      cfg_we_i, no wait    cfg_index_i, cfg_data_i
//
// load and clear are handled in idle without leaving it; in a solve the edge table and
// the distance memory, each with a single read port, are walked once per visited vertex.
// each result is read from the distance memory, then loaded into the output register;
// a stalled output holds the sequencer.
// reset clears the edge count and flags and returns the configuration to its defaults.
module single_source_shortest_path #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sssp_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sssp_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sssp_pkg::CFG_W-1:0]      cfg_data_i
);

  sssp_pkg::ctrl_t ctrl;
  sssp_pkg::stat_t stat;

  sssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  sssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/sssp_checker.sv @@
// port-level checks of the shortest path engine, bound to the top level
`include "single_source_shortest_path_defines.svh"

module sssp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sssp_pkg::out_t out_data_o
);

  // a pending result holds until taken
  `SSSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // no new item while a solve still has results to send
  `SSSP_ASSERT_IMP(a_busy_emit, clk_i, rst_ni, out_valid_o && !out_data_o.last, !in_ready_o, "item taken during result burst")

  // a stalled result keeps its payload
  `SSSP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")

  // unreachable vertices report zero distance
  `SSSP_ASSERT_IMP(a_unreach_zero, clk_i, rst_ni, out_valid_o && !out_data_o.reachable, out_data_o.distance == '0, "unreachable distance not zero")

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/tb_single_source_shortest_path.sv @@
// testbench for the single-source shortest path engine: directed table, then random graphs
`timescale 1ns / 100ps

module tb_single_source_shortest_path;

  localparam int NUM_VERTICES = sssp_pkg::MAX_VERTICES_DEF;
  localparam int NUM_EDGES    = sssp_pkg::MAX_EDGES_DEF;
  localparam int VTX_W        = sssp_pkg::VTX_W;
  localparam int WGT_W        = sssp_pkg::WGT_W;
  localparam int DIST_W       = sssp_pkg::DIST_W;
  localparam int CFG_W        = sssp_pkg::CFG_W;
  localparam int CMD_W        = sssp_pkg::CMD_W;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int TOTAL_ITEMS      = 410;
  localparam int QUIET_FROM       = 350;
  localparam int PHASE_PRESSURE   = 1;
  localparam int PHASE_FILL       = 3;
  localparam longint LIMIT_NS     = 200_000_000;

  typedef struct {
    bit                      is_cfg;
    sssp_pkg::reg_e          reg_idx;
    logic [CFG_W-1:0]        reg_val;
    sssp_pkg::in_t           item;
    bit                      typed;
    logic [NUM_VERTICES-1:0] reach_mask;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sssp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sssp_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [sssp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow of the edge table and registers
  logic [VTX_W-1:0] edge_tail [NUM_EDGES];
  logic [VTX_W-1:0] edge_head [NUM_EDGES];
  logic [WGT_W-1:0] edge_wgt [NUM_EDGES];
  int unsigned edges_held = 0;
  logic [sssp_pkg::CNT_W-1:0] vertex_count_reg = sssp_pkg::VCOUNT_RST;
  logic [VTX_W-1:0] source_reg = sssp_pkg::SOURCE_RST;

  sssp_pkg::out_t expected_reports [$];
  sssp_pkg::out_t want_report;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit long_hold_req = 1'b0;

  single_source_shortest_path dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned vertices_in_use();
    if (vertex_count_reg == 0) return 1;
    if (vertex_count_reg > NUM_VERTICES) return NUM_VERTICES;
    return vertex_count_reg;
  endfunction

  // edge table update, or a full Dijkstra pass producing one report per vertex
  function automatic void predict_paths(input sssp_pkg::in_t item);
    int unsigned n;
    int i;
    int e;
    int pick;
    logic [DIST_W-1:0] best_dist [NUM_VERTICES];
    bit done [NUM_VERTICES];
    bit reach [NUM_VERTICES];
    logic [DIST_W:0] cand;
    sssp_pkg::out_t rep;
    n = vertices_in_use();
    case (item.cmd)
      sssp_pkg::CMD_LOAD: begin
        // a full table drops the edge
        if (edges_held < NUM_EDGES) begin
          edge_tail[edges_held] = item.edge_source;
          edge_head[edges_held] = item.edge_target;
          edge_wgt[edges_held] = item.edge_weight;
          edges_held++;
        end
      end
      sssp_pkg::CMD_CLEAR: edges_held = 0;
      sssp_pkg::CMD_SOLVE: begin
        for (i = 0; i < NUM_VERTICES; i++) begin
          best_dist[i] = '0;
          done[i] = 1'b0;
          reach[i] = 1'b0;
        end
        if (source_reg < n) reach[source_reg] = 1'b1;
        pick = 0;
        while (pick >= 0) begin
          pick = -1;
          // strict less-than keeps the lowest vertex on ties
          for (i = 0; i < n; i++) begin
            if (!done[i] && reach[i] && (pick < 0 || best_dist[i] < best_dist[pick])) pick = i;
          end
          if (pick >= 0) begin
            done[pick] = 1'b1;
            for (e = 0; e < edges_held; e++) begin
              if (edge_tail[e] == pick && edge_head[e] < n) begin
                cand = best_dist[pick] + edge_wgt[e];
                if (cand > DIST_SAT) cand = DIST_SAT;
                if (!reach[edge_head[e]] || cand[DIST_W-1:0] < best_dist[edge_head[e]]) begin
                  best_dist[edge_head[e]] = cand[DIST_W-1:0];
                  reach[edge_head[e]] = 1'b1;
                end
              end
            end
          end
        end
        for (i = 0; i < n; i++) begin
          rep.vertex = VTX_W'(i);
          rep.distance = reach[i] ? best_dist[i] : '0;
          rep.reachable = reach[i];
          rep.last = (i == n - 1);
          expected_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic step_t item_step(input logic [CMD_W-1:0] code,
                                      input logic [VTX_W-1:0] tail,
                                      input logic [VTX_W-1:0] head,
                                      input logic [WGT_W-1:0] wgt,
                                      input bit typed,
                                      input logic [NUM_VERTICES-1:0] mask);
    step_t s;
    s.is_cfg = 1'b0;
    s.reg_idx = sssp_pkg::REG_VERTEX_COUNT;
    s.reg_val = '0;
    s.item.cmd = code;
    s.item.edge_source = tail;
    s.item.edge_target = head;
    s.item.edge_weight = wgt;
    s.typed = typed;
    s.reach_mask = mask;
    return s;
  endfunction

  function automatic step_t cfg_step(input sssp_pkg::reg_e idx, input logic [CFG_W-1:0] val);
    step_t s;
    s = item_step(sssp_pkg::CMD_LOAD, '0, '0, '0, 1'b0, '0);
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic sssp_pkg::in_t make_cmd(input logic [CMD_W-1:0] code);
    sssp_pkg::in_t it;
    it.cmd = code;
    it.edge_source = VTX_W'($urandom);
    it.edge_target = VTX_W'($urandom);
    it.edge_weight = WGT_W'($urandom);
    return it;
  endfunction

  function automatic sssp_pkg::in_t make_edge(input int unsigned n);
    sssp_pkg::in_t it;
    it.cmd = sssp_pkg::CMD_LOAD;
    if ($urandom_range(0, 9) == 0) begin
      it.edge_source = VTX_W'($urandom_range(0, 15));
      it.edge_target = VTX_W'($urandom_range(0, 15));
    end else begin
      it.edge_source = VTX_W'($urandom_range(0, n - 1));
      it.edge_target = VTX_W'($urandom_range(0, n - 1));
    end
    case ($urandom_range(0, 5))
      0: it.edge_weight = WGT_W'($urandom_range(0, 65535));
      1: it.edge_weight = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: it.edge_weight = WGT_W'($urandom_range(0, 20));
    endcase
    return it;
  endfunction

  // called at a clock edge; returns at the edge the item is taken
  task automatic send_item(input sssp_pkg::in_t item, input bit typed = 1'b0,
                           input logic [NUM_VERTICES-1:0] reach_mask = '0);
    sssp_pkg::out_t rep;
    int unsigned n;
    int i;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (typed && item.cmd == sssp_pkg::CMD_SOLVE) begin
      // all typed solves have zero distances on every reached vertex
      n = vertices_in_use();
      for (i = 0; i < n; i++) begin
        rep.vertex = VTX_W'(i);
        rep.distance = '0;
        rep.reachable = reach_mask[i];
        rep.last = (i == n - 1);
        expected_reports.push_back(rep);
      end
    end else begin
      predict_paths(item);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sssp_pkg::reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == sssp_pkg::REG_VERTEX_COUNT) vertex_count_reg = val;
    else source_reg = val[VTX_W-1:0];
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report vertex %0d distance %0d reachable %0b last %0b",
                   $realtime, out_data.vertex, out_data.distance, out_data.reachable,
                   out_data.last);
      end else begin
        want_report = expected_reports.pop_front();
        if (out_data.vertex !== want_report.vertex ||
            out_data.distance !== want_report.distance ||
            out_data.reachable !== want_report.reachable ||
            out_data.last !== want_report.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report mismatch got v%0d d%0d r%0b l%0b, expected v%0d d%0d r%0b l%0b",
                     $realtime, out_data.vertex, out_data.distance, out_data.reachable,
                     out_data.last, want_report.vertex, want_report.distance,
                     want_report.reachable, want_report.last);
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_single_source_shortest_path: FAIL");
    $finish;
  end

  initial begin
    step_t plan [$];
    int unsigned n;
    int unsigned phase;
    int loads;
    int k;
    logic [CFG_W-1:0] count_val;

    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h0001));
    plan.push_back(item_step(CMD_UNUSED, 4'hF, 4'hF, 16'hFFFF, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd0, 4'd1, 16'h0000, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd1, 4'd15, 16'h0000, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h8003));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd15, 4'd2, 16'hFFFF, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd2, 4'd3, 16'hFFFF, 1'b0, '0));
    // equal distances to 4 and 5
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd0, 4'd4, 16'd7, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd0, 4'd5, 16'd7, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd4, 4'd6, 16'd1, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd5, 4'd6, 16'd0, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_CLEAR, 4'd0, 4'd0, 16'd0, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h0001));
    plan.push_back(cfg_step(sssp_pkg::REG_VERTEX_COUNT, 5'd31));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd0, 4'd7, 16'd3, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b0, '0));
    plan.push_back(cfg_step(sssp_pkg::REG_VERTEX_COUNT, 5'd0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h0001));
    plan.push_back(cfg_step(sssp_pkg::REG_VERTEX_COUNT, 5'd1));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h0001));
    // source beyond the count: nothing reachable
    plan.push_back(cfg_step(sssp_pkg::REG_VERTEX_COUNT, 5'd4));
    plan.push_back(cfg_step(sssp_pkg::REG_SOURCE_VERTEX, 5'd15));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b1, 16'h0000));
    // edges leaving the graph are kept but skipped
    plan.push_back(cfg_step(sssp_pkg::REG_SOURCE_VERTEX, 5'd3));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd3, 4'd9, 16'd5, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd3, 4'd0, 16'd7, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd9, 4'd1, 16'd1, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b0, '0));
    plan.push_back(cfg_step(sssp_pkg::REG_VERTEX_COUNT, 5'd17));
    plan.push_back(cfg_step(sssp_pkg::REG_SOURCE_VERTEX, 5'd15));
    plan.push_back(item_step(sssp_pkg::CMD_LOAD, 4'd15, 4'd14, 16'hFFFF, 1'b0, '0));
    plan.push_back(item_step(sssp_pkg::CMD_SOLVE, 4'd0, 4'd0, 16'd0, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].reach_mask);
      end
    end

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      if (items_sent >= QUIET_FROM) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      if (phase == PHASE_PRESSURE || phase == PHASE_FILL) begin
        count_val = CFG_W'(NUM_VERTICES);
      end else begin
        case ($urandom_range(0, 7))
          0: count_val = CFG_W'($urandom_range(17, 31));
          1: count_val = CFG_W'($urandom_range(0, 1));
          2: count_val = CFG_W'(NUM_VERTICES);
          default: count_val = CFG_W'($urandom_range(2, 8));
        endcase
      end
      write_reg(sssp_pkg::REG_VERTEX_COUNT, count_val);
      n = vertices_in_use();
      write_reg(sssp_pkg::REG_SOURCE_VERTEX, ($urandom_range(0, 7) == 0) ?
                CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(0, n - 1)));

      if (phase == PHASE_PRESSURE) begin
        // the held output keeps one result and stalls the sequencer until input stalls
        send_item(make_cmd(sssp_pkg::CMD_CLEAR));
        for (k = 0; k < 8; k++) send_item(make_edge(n));
        long_hold_req = 1'b1;
        for (k = 0; k < 6; k++) send_item(make_cmd(sssp_pkg::CMD_SOLVE));
      end else if (phase == PHASE_FILL) begin
        // overrun the edge table
        send_item(make_cmd(sssp_pkg::CMD_CLEAR));
        for (k = 0; k < NUM_EDGES + 6; k++) send_item(make_edge(n));
        send_item(make_cmd(sssp_pkg::CMD_SOLVE));
        send_item(make_edge(n));
        send_item(make_cmd(sssp_pkg::CMD_SOLVE));
      end else begin
        if ($urandom_range(0, 4) != 0) send_item(make_cmd(sssp_pkg::CMD_CLEAR));
        loads = $urandom_range(0, 2 * n + 2);
        for (k = 0; k < loads; k++) begin
          if ($urandom_range(0, 15) == 0) send_item(make_cmd(CMD_UNUSED));
          send_item(make_edge(n));
        end
        send_item(make_cmd(sssp_pkg::CMD_SOLVE));
        if ($urandom_range(0, 2) == 0) begin
          loads = $urandom_range(1, 4);
          for (k = 0; k < loads; k++) send_item(make_edge(n));
          send_item(make_cmd(sssp_pkg::CMD_SOLVE));
        end
      end
      phase++;
    end

    settle();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_single_source_shortest_path: PASS");
    end else begin
      $display("tb_single_source_shortest_path: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sssp_pkg.sv
hw/rtl/sssp_ctrl.sv
hw/rtl/sssp_datapath.sv
hw/rtl/single_source_shortest_path.sv
hw/rtl/sssp_checker.sv
tb/tb_single_source_shortest_path.sv
